// File: rtl/aecp_pkg.sv
// Shared types, codes and constants of the escape-sequence cursor parser.
// Used by every module of the block; depends on nothing.
package aecp_pkg;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_W  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SCREEN_H  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_W   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_GLYPH_H   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_CR_ADDS_LF = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_LF_ADDS_CR = 3'd5;

    localparam logic [9:0] RESET_SCREEN_W = 10'd800;
    localparam logic [9:0] RESET_SCREEN_H = 10'd480;
    localparam logic [6:0] RESET_GLYPH_W  = 7'd8;
    localparam logic [6:0] RESET_GLYPH_H  = 7'd16;

    localparam logic [2:0] CMD_SET_CURSOR  = 3'd0;
    localparam logic [2:0] CMD_FILL_RECT   = 3'd1;
    localparam logic [2:0] CMD_SCROLL_UP   = 3'd2;
    localparam logic [2:0] CMD_SCROLL_DOWN = 3'd3;
    localparam logic [2:0] CMD_PRINT_CHAR  = 3'd4;

    localparam logic [7:0] CH_BS       = 8'd8;
    localparam logic [7:0] CH_LF       = 8'd10;
    localparam logic [7:0] CH_CR       = 8'd13;
    localparam logic [7:0] CH_ESC      = 8'd27;
    localparam logic [7:0] CH_SPACE    = 8'd32;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SEMI     = 8'h3B;
    localparam logic [7:0] CH_A        = 8'h41;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_C        = 8'h43;
    localparam logic [7:0] CH_D        = 8'h44;
    localparam logic [7:0] CH_E        = 8'h45;
    localparam logic [7:0] CH_F        = 8'h46;
    localparam logic [7:0] CH_G        = 8'h47;
    localparam logic [7:0] CH_H        = 8'h48;
    localparam logic [7:0] CH_J        = 8'h4A;
    localparam logic [7:0] CH_K        = 8'h4B;
    localparam logic [7:0] CH_L        = 8'h4C;
    localparam logic [7:0] CH_M        = 8'h4D;
    localparam logic [7:0] CH_S        = 8'h53;
    localparam logic [7:0] CH_T        = 8'h54;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_F_LOWER  = 8'h66;

    localparam logic [7:0] PARAM_LIMIT = 8'd100;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_ESC,
        PH_P1,
        PH_P2
    } phase_t;

    typedef enum logic [4:0] {
        OP_SCROLL_UP1,
        OP_SCROLL_DN1,
        OP_CR,
        OP_LF,
        OP_BS,
        OP_PRINT,
        OP_CUU,
        OP_CUD,
        OP_CUF,
        OP_CUB,
        OP_CNL,
        OP_CPL,
        OP_CHA,
        OP_CUP,
        OP_ED0,
        OP_ED1,
        OP_ED2,
        OP_EL0,
        OP_EL1,
        OP_EL2,
        OP_SU,
        OP_SD
    } op_t;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [10:0] cursor_x;
        logic [10:0] cursor_y;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  command;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic [9:0]  rect_w;
        logic [9:0]  rect_h;
        logic [7:0]  line_count;
        logic [6:0]  char_code;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic [9:0] screen_w;
        logic [9:0] screen_h;
        logic [6:0] glyph_w;
        logic [6:0] glyph_h;
        logic       cr_adds_lf;
        logic       lf_adds_cr;
    } cfg_t;

    typedef struct packed {
        op_t         op;
        logic [10:0] cx;
        logic [10:0] cy;
        logic [7:0]  mul_a;
        logic [7:0]  mul_b;
        logic [6:0]  ch;
    } op_item_t;

    typedef struct packed {
        op_t         op;
        logic [10:0] cx;
        logic [10:0] cy;
        logic [7:0]  line;
        logic [6:0]  ch;
        logic [13:0] prod_a;
        logic [13:0] prod_b;
    } stage_t;

endpackage

// File: rtl/ansi_escape_cursor_parser.sv
// Top level of the escape-sequence cursor parser: configuration registers and
// the front end, request queue and back end. Uses aecp_pkg and all aecp_ modules.
//
// Usage:
// The input channel (in_valid, in_stall, in_data) carries one received byte with
// the display's current pixel cursor per request. A request is taken at a clock
// edge where in_valid is high and in_stall is low.
// The output channel (out_valid, out_stall, out_data) carries display commands;
// each byte gives zero, one or two commands, and the final one has last set.
// A taken byte passes the request queue, the back end's held stage and the output
// register. One command is issued per cycle while out_stall is low, so bytes are
// taken every cycle while each gives at most one command; a two-command byte
// holds the back end until both are issued. A two-entry request queue sits between
// the parser and the command unit. When out_stall is high the output register holds
// its command, the back end waits, the queue fills, and then in_stall rises.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) take effect on the next
// edge and should be made only while the block is idle.
// Reset clears the parse state and queue and loads the default screen and
// glyph sizes (800 by 480, 8 by 16) with both line-end options enabled.
module ansi_escape_cursor_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  aecp_pkg::in_item_t                in_data,
    output logic                              out_valid,
    input  logic                              out_stall,
    output aecp_pkg::out_item_t               out_data,
    input  logic                              cfg_we,
    input  logic [aecp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [aecp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    aecp_pkg::cfg_t     cfg_reg;
    aecp_pkg::cfg_t     cfg_next;
    logic               q_full;
    logic               push;
    aecp_pkg::op_item_t push_item;
    logic               q_pop;
    aecp_pkg::op_item_t pop_item;
    logic               q_valid;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_addr)
                aecp_pkg::CFG_SCREEN_W:   cfg_next.screen_w   = cfg_wdata;
                aecp_pkg::CFG_SCREEN_H:   cfg_next.screen_h   = cfg_wdata;
                aecp_pkg::CFG_GLYPH_W:    cfg_next.glyph_w    = cfg_wdata[6:0];
                aecp_pkg::CFG_GLYPH_H:    cfg_next.glyph_h    = cfg_wdata[6:0];
                aecp_pkg::CFG_CR_ADDS_LF: cfg_next.cr_adds_lf = cfg_wdata[0];
                aecp_pkg::CFG_LF_ADDS_CR: cfg_next.lf_adds_cr = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.screen_w   <= aecp_pkg::RESET_SCREEN_W;
            cfg_reg.screen_h   <= aecp_pkg::RESET_SCREEN_H;
            cfg_reg.glyph_w    <= aecp_pkg::RESET_GLYPH_W;
            cfg_reg.glyph_h    <= aecp_pkg::RESET_GLYPH_H;
            cfg_reg.cr_adds_lf <= 1'b1;
            cfg_reg.lf_adds_cr <= 1'b1;
        end
        else
            cfg_reg <= cfg_next;
    end

    aecp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .q_full    (q_full),
        .push      (push),
        .push_item (push_item)
    );

    aecp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (pop_item),
        .not_empty (q_valid)
    );

    aecp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (pop_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// File: rtl/aecp_front.sv
// Front end: accepts received bytes, tracks the escape-parse state and parameters,
// and turns each byte that has an effect into an operation request. Uses aecp_pkg.
module aecp_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  aecp_pkg::in_item_t  in_data,
    input  logic                q_full,
    output logic                push,
    output aecp_pkg::op_item_t  push_item
);

    aecp_pkg::phase_t   phase_reg;
    aecp_pkg::phase_t   phase_next;
    logic [7:0]         p1_reg;
    logic [7:0]         p1_next;
    logic [7:0]         p2_reg;
    logic [7:0]         p2_next;
    logic               accept;
    logic [7:0]         b;
    logic               digit;
    logic [7:0]         n;
    logic [7:0]         col;
    logic               fin_has;
    aecp_pkg::op_t      fin_op;
    logic [7:0]         fin_mul_a;
    logic [7:0]         fin_mul_b;
    logic               has_op;
    aecp_pkg::op_item_t item;

    function automatic logic [7:0] take_digit(input logic [7:0] p, input logic [3:0] d);
        logic [7:0] grown;
        grown = {p[4:0], 3'b000} + {p[6:0], 1'b0} + {4'b0000, d};
        return (p < aecp_pkg::PARAM_LIMIT) ? grown : p;
    endfunction

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign b        = in_data.rx_byte;
    assign digit    = (b >= aecp_pkg::CH_ZERO) && (b <= aecp_pkg::CH_NINE);
    assign n        = (p1_reg == 8'd0) ? 8'd1 : p1_reg;
    assign col      = (p2_reg == 8'd0) ? 8'd0 : p2_reg - 8'd1;

    always_comb
    begin
        fin_has   = 1'b1;
        fin_op    = aecp_pkg::OP_CUU;
        fin_mul_a = n;
        fin_mul_b = n;
        unique case (b)
            aecp_pkg::CH_A: fin_op = aecp_pkg::OP_CUU;
            aecp_pkg::CH_B: fin_op = aecp_pkg::OP_CUD;
            aecp_pkg::CH_C: fin_op = aecp_pkg::OP_CUF;
            aecp_pkg::CH_D: fin_op = aecp_pkg::OP_CUB;
            aecp_pkg::CH_E: fin_op = aecp_pkg::OP_CNL;
            aecp_pkg::CH_F: fin_op = aecp_pkg::OP_CPL;
            aecp_pkg::CH_G:
            begin
                fin_op    = aecp_pkg::OP_CHA;
                fin_mul_a = n - 8'd1;
            end
            aecp_pkg::CH_H, aecp_pkg::CH_F_LOWER:
            begin
                fin_op    = aecp_pkg::OP_CUP;
                fin_mul_a = col;
                fin_mul_b = n - 8'd1;
            end
            aecp_pkg::CH_J:
            begin
                priority if (p1_reg == 8'd0)
                    fin_op = aecp_pkg::OP_ED0;
                else if (p1_reg == 8'd1)
                    fin_op = aecp_pkg::OP_ED1;
                else if (p1_reg == 8'd2)
                    fin_op = aecp_pkg::OP_ED2;
                else
                    fin_has = 1'b0;
            end
            aecp_pkg::CH_K:
            begin
                priority if (p1_reg == 8'd0)
                    fin_op = aecp_pkg::OP_EL0;
                else if (p1_reg == 8'd1)
                    fin_op = aecp_pkg::OP_EL1;
                else if (p1_reg == 8'd2)
                    fin_op = aecp_pkg::OP_EL2;
                else
                    fin_has = 1'b0;
            end
            aecp_pkg::CH_S: fin_op = aecp_pkg::OP_SU;
            aecp_pkg::CH_T: fin_op = aecp_pkg::OP_SD;
            default:        fin_has = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        p1_next    = p1_reg;
        p2_next    = p2_reg;
        has_op     = 1'b0;
        item.op    = aecp_pkg::OP_CR;
        item.cx    = in_data.cursor_x;
        item.cy    = in_data.cursor_y;
        item.mul_a = n;
        item.mul_b = n;
        item.ch    = b[6:0];
        if (accept)
        begin
            unique case (phase_reg)
                aecp_pkg::PH_ESC:
                begin
                    phase_next = aecp_pkg::PH_IDLE;
                    priority if (b == aecp_pkg::CH_LBRACKET)
                    begin
                        phase_next = aecp_pkg::PH_P1;
                        p1_next    = 8'd0;
                        p2_next    = 8'd0;
                    end
                    else if (b == aecp_pkg::CH_M)
                    begin
                        has_op     = 1'b1;
                        item.op    = aecp_pkg::OP_SCROLL_UP1;
                        item.mul_b = 8'd1;
                    end
                    else if (b == aecp_pkg::CH_L)
                    begin
                        has_op     = 1'b1;
                        item.op    = aecp_pkg::OP_SCROLL_DN1;
                        item.mul_b = 8'd1;
                    end
                end
                aecp_pkg::PH_P1:
                begin
                    priority if (digit)
                        p1_next = take_digit(p1_reg, b[3:0]);
                    else if (b == aecp_pkg::CH_SEMI)
                        phase_next = aecp_pkg::PH_P2;
                    else
                    begin
                        phase_next = aecp_pkg::PH_IDLE;
                        has_op     = fin_has;
                        item.op    = fin_op;
                        item.mul_a = fin_mul_a;
                        item.mul_b = fin_mul_b;
                    end
                end
                aecp_pkg::PH_P2:
                begin
                    if (digit)
                        p2_next = take_digit(p2_reg, b[3:0]);
                    else
                    begin
                        phase_next = aecp_pkg::PH_IDLE;
                        has_op     = fin_has;
                        item.op    = fin_op;
                        item.mul_a = fin_mul_a;
                        item.mul_b = fin_mul_b;
                    end
                end
                aecp_pkg::PH_IDLE:
                begin
                    priority if (b == aecp_pkg::CH_CR)
                    begin
                        has_op  = 1'b1;
                        item.op = aecp_pkg::OP_CR;
                    end
                    else if (b == aecp_pkg::CH_LF)
                    begin
                        has_op  = 1'b1;
                        item.op = aecp_pkg::OP_LF;
                    end
                    else if (b == aecp_pkg::CH_BS)
                    begin
                        has_op  = 1'b1;
                        item.op = aecp_pkg::OP_BS;
                    end
                    else if (b == aecp_pkg::CH_ESC)
                    begin
                        phase_next = aecp_pkg::PH_ESC;
                        p1_next    = 8'd0;
                        p2_next    = 8'd0;
                    end
                    else if ((b >= aecp_pkg::CH_SPACE) && !b[7])
                    begin
                        has_op  = 1'b1;
                        item.op = aecp_pkg::OP_PRINT;
                    end
                end
                default: ;
            endcase
        end
    end

    assign push      = has_op;
    assign push_item = item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= aecp_pkg::PH_IDLE;
            p1_reg    <= 8'd0;
            p2_reg    <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            p1_reg    <= p1_next;
            p2_reg    <= p2_next;
        end
    end

endmodule

// File: rtl/aecp_queue.sv
// Short register queue of operation requests between the front and back ends.
// Uses aecp_pkg for the entry type and depth.
module aecp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  aecp_pkg::op_item_t  push_item,
    output logic                full,
    input  logic                pop,
    output aecp_pkg::op_item_t  pop_item,
    output logic                not_empty
);

    aecp_pkg::op_item_t                    entry_reg [aecp_pkg::QUEUE_DEPTH];
    logic [aecp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_reg;
    logic [aecp_pkg::QUEUE_PTR_W-1:0]      wr_ptr_next;
    logic [aecp_pkg::QUEUE_PTR_W-1:0]      rd_ptr_reg;
    logic [aecp_pkg::QUEUE_PTR_W-1:0]      rd_ptr_next;
    logic [aecp_pkg::QUEUE_CNT_W-1:0]      count_reg;
    logic [aecp_pkg::QUEUE_CNT_W-1:0]      count_next;

    localparam logic [aecp_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
        aecp_pkg::QUEUE_PTR_W'(aecp_pkg::QUEUE_DEPTH - 1);
    localparam logic [aecp_pkg::QUEUE_CNT_W-1:0] FULL_COUNT =
        aecp_pkg::QUEUE_CNT_W'(aecp_pkg::QUEUE_DEPTH);
    localparam logic [aecp_pkg::QUEUE_CNT_W-1:0] COUNT_ONE =
        aecp_pkg::QUEUE_CNT_W'(1);

    assign full      = (count_reg == FULL_COUNT);
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + COUNT_ONE;
        else if (pop && !push)
            count_next = count_reg - COUNT_ONE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// File: rtl/aecp_back.sv
// Back end: multiplies cell counts by the glyph size, clamps positions and extents,
// and issues up to two display commands per request. Uses aecp_pkg.
module aecp_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  aecp_pkg::cfg_t       cfg,
    input  logic                 q_valid,
    input  aecp_pkg::op_item_t   q_item,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_stall,
    output aecp_pkg::out_item_t  out_data
);

    aecp_pkg::stage_t    s1_reg;
    aecp_pkg::stage_t    s1_next;
    logic                s1_valid_reg;
    logic                s1_valid_next;
    logic                idx_reg;
    logic                idx_next;
    aecp_pkg::out_item_t out_reg;
    aecp_pkg::out_item_t out_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                out_load;
    logic                emit_last;
    logic                s1_done;
    logic [14:0]         mul_a_full;
    logic [14:0]         mul_b_full;

    logic [9:0]          clamp_x;
    logic [9:0]          clamp_y;
    logic [14:0]         down_y;
    logic [13:0]         move_down_y;
    logic [10:0]         up_y;
    logic [14:0]         right_x;
    logic [13:0]         move_right_x;
    logic [10:0]         left_x;
    logic [13:0]         cha_x;
    logic [11:0]         lf_y;
    logic                lf_hit;
    logic [13:0]         lf_pos_y;
    logic [10:0]         lf_x;
    logic [10:0]         bs_x;
    logic [11:0]         cr_y;
    logic                print_scroll;
    logic [9:0]          w_right;
    logic [9:0]          h_below;
    logic [10:0]         above_diff;
    logic [9:0]          h_above;
    logic [9:0]          cx_w;
    logic                two;
    aecp_pkg::out_item_t res_a;
    aecp_pkg::out_item_t res_b;

    function automatic aecp_pkg::out_item_t make_res(
        input logic [2:0]  cmd,
        input logic [13:0] x,
        input logic [13:0] y,
        input logic [9:0]  w,
        input logic [9:0]  h,
        input logic [7:0]  n,
        input logic [6:0]  c
    );
        aecp_pkg::out_item_t r;
        r.command    = cmd;
        r.pos_x      = x;
        r.pos_y      = y;
        r.rect_w     = w;
        r.rect_h     = h;
        r.line_count = n;
        r.char_code  = c;
        r.last       = 1'b0;
        return r;
    endfunction

    // Stage one: take a request from the queue and scale its cell counts.
    assign mul_a_full = {7'b0, q_item.mul_a} * {8'b0, cfg.glyph_w};
    assign mul_b_full = {7'b0, q_item.mul_b} * {8'b0, cfg.glyph_h};

    always_comb
    begin
        s1_next.op     = q_item.op;
        s1_next.cx     = q_item.cx;
        s1_next.cy     = q_item.cy;
        s1_next.line   = q_item.mul_b;
        s1_next.ch     = q_item.ch;
        s1_next.prod_a = mul_a_full[13:0];
        s1_next.prod_b = mul_b_full[13:0];
    end

    // Stage two: clamp and build the commands of the held request.
    assign clamp_x      = (cfg.screen_w >= {3'b0, cfg.glyph_w}) ?
                          cfg.screen_w - {3'b0, cfg.glyph_w} : 10'd0;
    assign clamp_y      = (cfg.screen_h >= {3'b0, cfg.glyph_h}) ?
                          cfg.screen_h - {3'b0, cfg.glyph_h} : 10'd0;
    assign down_y       = {4'b0, s1_reg.cy} + {1'b0, s1_reg.prod_b};
    assign move_down_y  = (down_y >= {5'b0, cfg.screen_h}) ? {4'b0, clamp_y} : down_y[13:0];
    assign up_y         = ({3'b0, s1_reg.cy} >= s1_reg.prod_b) ?
                          s1_reg.cy - s1_reg.prod_b[10:0] : 11'd0;
    assign right_x      = {4'b0, s1_reg.cx} + {1'b0, s1_reg.prod_a};
    assign move_right_x = (right_x >= {5'b0, cfg.screen_w}) ? {4'b0, clamp_x} : right_x[13:0];
    assign left_x       = ({3'b0, s1_reg.cx} >= s1_reg.prod_a) ?
                          s1_reg.cx - s1_reg.prod_a[10:0] : 11'd0;
    assign cha_x        = (s1_reg.prod_a >= {4'b0, cfg.screen_w}) ?
                          {4'b0, clamp_x} : s1_reg.prod_a;
    assign lf_y         = {1'b0, s1_reg.cy} + {5'b0, cfg.glyph_h};
    assign lf_hit       = (lf_y >= {2'b0, cfg.screen_h});
    assign lf_pos_y     = lf_hit ? {4'b0, clamp_y} : {2'b0, lf_y};
    assign lf_x         = cfg.lf_adds_cr ? 11'd0 : s1_reg.cx;
    assign bs_x         = (s1_reg.cx >= {4'b0, cfg.glyph_w}) ?
                          s1_reg.cx - {4'b0, cfg.glyph_w} : 11'd0;
    assign cr_y         = {1'b0, s1_reg.cy} + (cfg.cr_adds_lf ? {5'b0, cfg.glyph_h} : 12'd0);
    assign print_scroll = (s1_reg.cy >= {1'b0, cfg.screen_h});
    assign w_right      = ({1'b0, cfg.screen_w} > s1_reg.cx) ?
                          cfg.screen_w - s1_reg.cx[9:0] : 10'd0;
    assign h_below      = ({2'b0, cfg.screen_h} > lf_y) ?
                          cfg.screen_h - lf_y[9:0] : 10'd0;
    assign above_diff   = s1_reg.cy - {4'b0, cfg.glyph_h};
    assign h_above      = (s1_reg.cy > {4'b0, cfg.glyph_h}) ?
                          (above_diff[10] ? 10'h3FF : above_diff[9:0]) : 10'd0;
    assign cx_w         = s1_reg.cx[10] ? 10'h3FF : s1_reg.cx[9:0];

    always_comb
    begin
        res_a = '0;
        res_b = '0;
        two   = 1'b0;
        unique case (s1_reg.op)
            aecp_pkg::OP_SCROLL_UP1, aecp_pkg::OP_SU:
                res_a = make_res(aecp_pkg::CMD_SCROLL_UP, '0, '0, '0, '0, s1_reg.line, '0);
            aecp_pkg::OP_SCROLL_DN1, aecp_pkg::OP_SD:
                res_a = make_res(aecp_pkg::CMD_SCROLL_DOWN, '0, '0, '0, '0, s1_reg.line, '0);
            aecp_pkg::OP_CR:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, '0, 14'(cr_y), '0, '0, '0, '0);
            aecp_pkg::OP_LF:
            begin
                if (lf_hit)
                begin
                    two   = 1'b1;
                    res_a = make_res(aecp_pkg::CMD_SCROLL_UP, '0, '0, '0, '0, 8'd1, '0);
                    res_b = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(lf_x), lf_pos_y,
                                     '0, '0, '0, '0);
                end
                else
                    res_a = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(lf_x), lf_pos_y,
                                     '0, '0, '0, '0);
            end
            aecp_pkg::OP_BS:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(bs_x), 14'(s1_reg.cy),
                                 '0, '0, '0, '0);
            aecp_pkg::OP_PRINT:
            begin
                if (print_scroll)
                begin
                    two   = 1'b1;
                    res_a = make_res(aecp_pkg::CMD_SCROLL_UP, '0, '0, '0, '0, 8'd1, '0);
                    res_b = make_res(aecp_pkg::CMD_PRINT_CHAR, '0, '0, '0, '0, '0, s1_reg.ch);
                end
                else
                    res_a = make_res(aecp_pkg::CMD_PRINT_CHAR, '0, '0, '0, '0, '0, s1_reg.ch);
            end
            aecp_pkg::OP_CUU:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(s1_reg.cx), 14'(up_y),
                                 '0, '0, '0, '0);
            aecp_pkg::OP_CUD:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(s1_reg.cx), move_down_y,
                                 '0, '0, '0, '0);
            aecp_pkg::OP_CUF:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, move_right_x, 14'(s1_reg.cy),
                                 '0, '0, '0, '0);
            aecp_pkg::OP_CUB:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, 14'(left_x), 14'(s1_reg.cy),
                                 '0, '0, '0, '0);
            aecp_pkg::OP_CNL:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, '0, move_down_y, '0, '0, '0, '0);
            aecp_pkg::OP_CPL:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, '0, 14'(up_y), '0, '0, '0, '0);
            aecp_pkg::OP_CHA:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, cha_x, 14'(s1_reg.cy),
                                 '0, '0, '0, '0);
            aecp_pkg::OP_CUP:
                res_a = make_res(aecp_pkg::CMD_SET_CURSOR, s1_reg.prod_a, s1_reg.prod_b,
                                 '0, '0, '0, '0);
            aecp_pkg::OP_ED0:
            begin
                res_b = make_res(aecp_pkg::CMD_FILL_RECT, '0, 14'(lf_y), cfg.screen_w,
                                 h_below, '0, '0);
                if (s1_reg.cx != 11'd0)
                begin
                    two   = 1'b1;
                    res_a = make_res(aecp_pkg::CMD_FILL_RECT, 14'(s1_reg.cx), 14'(s1_reg.cy),
                                     w_right, 10'(cfg.glyph_h), '0, '0);
                end
                else
                    res_a = res_b;
            end
            aecp_pkg::OP_ED1:
            begin
                res_b = make_res(aecp_pkg::CMD_FILL_RECT, '0, '0, cfg.screen_w,
                                 h_above, '0, '0);
                if (s1_reg.cx != 11'd0)
                begin
                    two   = 1'b1;
                    res_a = make_res(aecp_pkg::CMD_FILL_RECT, '0, 14'(s1_reg.cy),
                                     cx_w, 10'(cfg.glyph_h), '0, '0);
                end
                else
                    res_a = res_b;
            end
            aecp_pkg::OP_ED2:
            begin
                two   = 1'b1;
                res_a = make_res(aecp_pkg::CMD_FILL_RECT, '0, '0, cfg.screen_w,
                                 cfg.screen_h, '0, '0);
                res_b = make_res(aecp_pkg::CMD_SET_CURSOR, '0, '0, '0, '0, '0, '0);
            end
            aecp_pkg::OP_EL0:
                res_a = make_res(aecp_pkg::CMD_FILL_RECT, 14'(s1_reg.cx), 14'(s1_reg.cy),
                                 w_right, 10'(cfg.glyph_h), '0, '0);
            aecp_pkg::OP_EL1:
                res_a = make_res(aecp_pkg::CMD_FILL_RECT, '0, 14'(s1_reg.cy),
                                 cx_w, 10'(cfg.glyph_h), '0, '0);
            aecp_pkg::OP_EL2:
                res_a = make_res(aecp_pkg::CMD_FILL_RECT, '0, 14'(s1_reg.cy),
                                 cfg.screen_w, 10'(cfg.glyph_h), '0, '0);
            default: ;
        endcase
    end

    assign emit_last = !two || idx_reg;
    assign out_load  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign s1_done   = out_load && emit_last;
    assign q_pop     = q_valid && (!s1_valid_reg || s1_done);

    always_comb
    begin
        out_next      = idx_reg ? res_b : res_a;
        out_next.last = emit_last;
        if (out_load)
            out_valid_next = 1'b1;
        else
            out_valid_next = out_valid_reg && out_stall;
        if (out_load)
            idx_next = !emit_last;
        else
            idx_next = idx_reg;
        if (q_pop)
            s1_valid_next = 1'b1;
        else if (s1_done)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            idx_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            s1_reg <= s1_next;
        if (out_load)
            out_reg <= out_next;
    end

`ifndef SYNTH
    assert property (@(posedge clk) disable iff (!rst_n) idx_reg |-> s1_valid_reg)
        else $error("second command pending without a held request");
    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("queue popped while empty");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !emit_last) |=> (idx_reg && s1_valid_reg))
        else $error("held request lost before its second command");
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_load) |=> (s1_valid_reg && $stable(idx_reg)))
        else $error("held request changed while output was blocked");
`endif

endmodule

// File: sim/aecp_check_pkg.sv
// Scoreboard for the escape-sequence cursor parser: predicts the display commands
// of each accepted request and checks the commands that the block returns.
// Depends on aecp_pkg for the request, command and register types.
package aecp_check_pkg;

    import aecp_pkg::*;

    class parser_scoreboard;

        cfg_t        regs;
        phase_t      phase;
        logic [7:0]  p1;
        logic [7:0]  p2;
        out_item_t   step_cmds[$];
        out_item_t   pending_commands[$];
        int          errors;
        int          checked;

        function new();
            regs.screen_w = RESET_SCREEN_W;
            regs.screen_h = RESET_SCREEN_H;
            regs.glyph_w = RESET_GLYPH_W;
            regs.glyph_h = RESET_GLYPH_H;
            regs.cr_adds_lf = 1'b1;
            regs.lf_adds_cr = 1'b1;
            phase = PH_IDLE;
            p1 = '0;
            p2 = '0;
            errors = 0;
            checked = 0;
        endfunction

        function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                CFG_SCREEN_W:   regs.screen_w = value;
                CFG_SCREEN_H:   regs.screen_h = value;
                CFG_GLYPH_W:    regs.glyph_w = value[6:0];
                CFG_GLYPH_H:    regs.glyph_h = value[6:0];
                CFG_CR_ADDS_LF: regs.cr_adds_lf = value[0];
                CFG_LF_ADDS_CR: regs.lf_adds_cr = value[0];
                default: ;
            endcase
        endfunction

        function int clip(int v, int hi);
            if (v < 0)
            begin
                return 0;
            end
            return (v > hi) ? hi : v;
        endfunction

        function int floor0(int v);
            return (v < 0) ? 0 : v;
        endfunction

        function int clamp_high(int v, int lim, int glyph);
            return (v >= lim) ? floor0(lim - glyph) : v;
        endfunction

        function logic [7:0] next_param(logic [7:0] p, logic [7:0] d);
            return (p < PARAM_LIMIT) ? p * 8'd10 + d : p;
        endfunction

        function void add(logic [2:0] cmd, int x, int y, int w, int h, int n, int c);
            out_item_t e;
            e = '0;
            e.command = cmd;
            e.pos_x = 14'(clip(x, 16383));
            e.pos_y = 14'(clip(y, 16383));
            e.rect_w = 10'(clip(w, 1023));
            e.rect_h = 10'(clip(h, 1023));
            e.line_count = n[7:0];
            e.char_code = c[6:0];
            step_cmds.insert(step_cmds.size(), e);
        endfunction

        function void csi_final(logic [7:0] fin, int cx, int cy);
            int sw = int'(regs.screen_w);
            int sh = int'(regs.screen_h);
            int gw = int'(regs.glyph_w);
            int gh = int'(regs.glyph_h);
            int a = int'(p1);
            int b = int'(p2);
            int n = (a < 1) ? 1 : a;
            case (fin)
                CH_A: add(CMD_SET_CURSOR, cx, floor0(cy - n * gh), 0, 0, 0, 0);
                CH_B: add(CMD_SET_CURSOR, cx, clamp_high(cy + n * gh, sh, gh), 0, 0, 0, 0);
                CH_C: add(CMD_SET_CURSOR, clamp_high(cx + n * gw, sw, gw), cy, 0, 0, 0, 0);
                CH_D: add(CMD_SET_CURSOR, floor0(cx - n * gw), cy, 0, 0, 0, 0);
                CH_E: add(CMD_SET_CURSOR, 0, clamp_high(cy + n * gh, sh, gh), 0, 0, 0, 0);
                CH_F: add(CMD_SET_CURSOR, 0, floor0(cy - n * gh), 0, 0, 0, 0);
                CH_G: add(CMD_SET_CURSOR, clamp_high((n - 1) * gw, sw, gw), cy, 0, 0, 0, 0);
                CH_H, CH_F_LOWER:
                begin
                    add(CMD_SET_CURSOR, ((b > 0) ? b - 1 : 0) * gw,
                        ((a > 0) ? a - 1 : 0) * gh, 0, 0, 0, 0);
                end
                CH_J:
                begin
                    if (a == 0)
                    begin
                        if (cx != 0)
                        begin
                            add(CMD_FILL_RECT, cx, cy, sw - cx, gh, 0, 0);
                        end
                        add(CMD_FILL_RECT, 0, cy + gh, sw, sh - (cy + gh), 0, 0);
                    end
                    else if (a == 1)
                    begin
                        if (cx != 0)
                        begin
                            add(CMD_FILL_RECT, 0, cy, cx, gh, 0, 0);
                        end
                        add(CMD_FILL_RECT, 0, 0, sw, cy - gh, 0, 0);
                    end
                    else if (a == 2)
                    begin
                        add(CMD_FILL_RECT, 0, 0, sw, sh, 0, 0);
                        add(CMD_SET_CURSOR, 0, 0, 0, 0, 0, 0);
                    end
                end
                CH_K:
                begin
                    if (a == 0)
                    begin
                        add(CMD_FILL_RECT, cx, cy, sw - cx, gh, 0, 0);
                    end
                    else if (a == 1)
                    begin
                        add(CMD_FILL_RECT, 0, cy, cx, gh, 0, 0);
                    end
                    else if (a == 2)
                    begin
                        add(CMD_FILL_RECT, 0, cy, sw, gh, 0, 0);
                    end
                end
                CH_S: add(CMD_SCROLL_UP, 0, 0, 0, 0, n, 0);
                CH_T: add(CMD_SCROLL_DOWN, 0, 0, 0, 0, n, 0);
                default: ;
            endcase
        endfunction

        function void note_request(in_item_t req);
            logic [7:0] b = req.rx_byte;
            int cx = int'(req.cursor_x);
            int cy = int'(req.cursor_y);
            int sh = int'(regs.screen_h);
            int gh = int'(regs.glyph_h);
            int gw = int'(regs.glyph_w);
            int y;
            bit digit;
            step_cmds.delete();
            digit = (b >= CH_ZERO) && (b <= CH_NINE);
            case (phase)
                PH_ESC:
                begin
                    phase = PH_IDLE;
                    if (b == CH_LBRACKET)
                    begin
                        phase = PH_P1;
                        p1 = '0;
                        p2 = '0;
                    end
                    else if (b == CH_M)
                    begin
                        add(CMD_SCROLL_UP, 0, 0, 0, 0, 1, 0);
                    end
                    else if (b == CH_L)
                    begin
                        add(CMD_SCROLL_DOWN, 0, 0, 0, 0, 1, 0);
                    end
                end
                PH_P1:
                begin
                    if (digit)
                    begin
                        p1 = next_param(p1, b - CH_ZERO);
                    end
                    else if (b == CH_SEMI)
                    begin
                        phase = PH_P2;
                    end
                    else
                    begin
                        phase = PH_IDLE;
                        csi_final(b, cx, cy);
                    end
                end
                PH_P2:
                begin
                    if (digit)
                    begin
                        p2 = next_param(p2, b - CH_ZERO);
                    end
                    else
                    begin
                        phase = PH_IDLE;
                        csi_final(b, cx, cy);
                    end
                end
                default:
                begin
                    if (b == CH_CR)
                    begin
                        add(CMD_SET_CURSOR, 0, cy + (regs.cr_adds_lf ? gh : 0), 0, 0, 0, 0);
                    end
                    else if (b == CH_LF)
                    begin
                        y = cy + gh;
                        if (y >= sh)
                        begin
                            add(CMD_SCROLL_UP, 0, 0, 0, 0, 1, 0);
                            y = floor0(sh - gh);
                        end
                        add(CMD_SET_CURSOR, regs.lf_adds_cr ? 0 : cx, y, 0, 0, 0, 0);
                    end
                    else if (b == CH_BS)
                    begin
                        add(CMD_SET_CURSOR, floor0(cx - gw), cy, 0, 0, 0, 0);
                    end
                    else if (b == CH_ESC)
                    begin
                        phase = PH_ESC;
                        p1 = '0;
                        p2 = '0;
                    end
                    else if (b >= CH_SPACE && b[7] == 1'b0)
                    begin
                        if (cy >= sh)
                        begin
                            add(CMD_SCROLL_UP, 0, 0, 0, 0, 1, 0);
                        end
                        add(CMD_PRINT_CHAR, 0, 0, 0, 0, 0, int'(b));
                    end
                end
            endcase
            if (step_cmds.size() > 0)
            begin
                step_cmds[step_cmds.size() - 1].last = 1'b1;
            end
            foreach (step_cmds[i])
            begin
                pending_commands.insert(pending_commands.size(), step_cmds[i]);
            end
        endfunction

        task report(string msg);
            errors++;
            $display("result %0d: %s", checked, msg);
        endtask

        task compare(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
            begin
                report($sformatf("%s is %0d, expected %0d", name, got, want));
            end
        endtask

        task check_command(out_item_t got);
            out_item_t want;
            checked++;
            if (pending_commands.size() == 0)
            begin
                report("command arrived with none outstanding");
                return;
            end
            want = pending_commands.pop_front();
            compare("command", 16'(got.command), 16'(want.command));
            compare("pos_x", 16'(got.pos_x), 16'(want.pos_x));
            compare("pos_y", 16'(got.pos_y), 16'(want.pos_y));
            compare("rect_w", 16'(got.rect_w), 16'(want.rect_w));
            compare("rect_h", 16'(got.rect_h), 16'(want.rect_h));
            compare("line_count", 16'(got.line_count), 16'(want.line_count));
            compare("char_code", 16'(got.char_code), 16'(want.char_code));
            compare("last", 16'(got.last), 16'(want.last));
        endtask

        task report_leftovers();
            out_item_t want;
            while (pending_commands.size() > 0)
            begin
                want = pending_commands.pop_front();
                report($sformatf("command %0d never arrived", want.command));
            end
        endtask

    endclass

endpackage

// File: sim/tb.sv
// Testbench of the escape-sequence cursor parser: directed control bytes and escape sequences, then
// random byte streams under several screen settings with random idling.
// Depends on aecp_pkg, aecp_check_pkg and the ansi_escape_cursor_parser RTL.
module tb;

    import aecp_pkg::*;
    import aecp_check_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_data;
    logic                  cfg_we;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    parser_scoreboard sb;
    bit               steady;
    int               sent;

    ansi_escape_cursor_parser i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

    // The receiver stalls at random, and once holds off long enough for the
    // block to fill up and stall new requests.
    initial
    begin
        int hold;
        bit held;
        hold = 0;
        held = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                sb.check_command(out_data);
            end
            if (!held && sb.checked >= 500 && in_valid)
            begin
                held = 1;
                hold = 400;
            end
            if (hold > 0)
            begin
                hold--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !steady && ($urandom_range(0, 99) < 29);
            end
        end
    end

    function automatic logic [10:0] pick_coord(int span, int glyph);
        int lim;
        lim = span + 2 * glyph;
        if (lim > 2047)
        begin
            lim = 2047;
        end
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return 11'($urandom_range(0, 2047));
            default: return 11'($urandom_range(0, lim));
        endcase
    endfunction

    task automatic send_at(logic [7:0] b, logic [10:0] x, logic [10:0] y);
        in_item_t req;
        req.rx_byte = b;
        req.cursor_x = x;
        req.cursor_y = y;
        while (!steady && $urandom_range(0, 99) < 29)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        sb.note_request(req);
        sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_at(b, pick_coord(int'(sb.regs.screen_w), int'(sb.regs.glyph_w)),
                pick_coord(int'(sb.regs.screen_h), int'(sb.regs.glyph_h)));
    endtask

    task automatic send_digits();
        int count;
        case ($urandom_range(0, 3))
            0: count = 0;
            1: count = -1;
            2: count = $urandom_range(1, 2);
            default: count = $urandom_range(3, 5);
        endcase
        if (count < 0)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 3)));
        end
        for (int i = 0; i < count; i++)
        begin
            send_byte(CH_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    task automatic random_sequence();
        int kind;
        int pick;
        kind = $urandom_range(0, 99);
        if (kind < 30)
        begin
            send_byte(8'($urandom_range(32, 127)));
        end
        else if (kind < 40)
        begin
            case ($urandom_range(0, 2))
                0: send_byte(CH_CR);
                1: send_byte(CH_LF);
                default: send_byte(CH_BS);
            endcase
        end
        else if (kind < 50)
        begin
            send_byte(CH_ESC);
            case ($urandom_range(0, 3))
                0: send_byte(CH_M);
                1: send_byte(CH_L);
                2: send_byte(8'($urandom_range(0, 255)));
                default: send_byte(CH_LBRACKET);
            endcase
        end
        else if (kind < 88)
        begin
            send_byte(CH_ESC);
            send_byte(CH_LBRACKET);
            send_digits();
            if ($urandom_range(0, 1) == 0)
            begin
                send_byte(CH_SEMI);
                send_digits();
            end
            pick = $urandom_range(0, 15);
            case (pick)
                0, 1, 2, 3, 4, 5, 6: send_byte(CH_A + 8'(pick));
                7: send_byte(CH_H);
                8: send_byte(CH_F_LOWER);
                9, 10: send_byte(CH_J);
                11: send_byte(CH_K);
                12: send_byte(CH_S);
                13: send_byte(CH_T);
                14: send_byte(CH_SEMI);
                default: send_byte(8'($urandom_range(0, 255)));
            endcase
        end
        else
        begin
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    task automatic write_config(int sw, int sh, int gw, int gh, bit crlf, bit lfcr);
        write_reg(CFG_SCREEN_W, CFG_DATA_W'(sw));
        write_reg(CFG_SCREEN_H, CFG_DATA_W'(sh));
        write_reg(CFG_GLYPH_W, CFG_DATA_W'(gw));
        write_reg(CFG_GLYPH_H, CFG_DATA_W'(gh));
        write_reg(CFG_CR_ADDS_LF, CFG_DATA_W'(crlf));
        write_reg(CFG_LF_ADDS_CR, CFG_DATA_W'(lfcr));
        cfg_we <= 1'b0;
    endtask

    task automatic drain();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        while (sb.pending_commands.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
    endtask

    task automatic random_phase(int count);
        int target;
        target = sent + count;
        while (sent < target)
        begin
            random_sequence();
        end
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        steady = 0;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_at(CH_A, 11'd0, 11'd0);
        send_at(8'h7F, 11'd5, 11'd480);
        send_at(CH_CR, 11'd799, 11'd2047);
        send_at(CH_LF, 11'd100, 11'd470);
        send_at(CH_BS, 11'd3, 11'd40);
        send_at(8'hFF, 11'd2047, 11'd2047);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(CH_M, 11'd0, 11'd0);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(CH_L, 11'd0, 11'd0);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(8'h00, 11'd0, 11'd0);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(CH_LBRACKET, 11'd0, 11'd0);
        send_at(CH_ZERO + 8'd2, 11'd0, 11'd0);
        send_at(CH_J, 11'd10, 11'd20);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(CH_LBRACKET, 11'd0, 11'd0);
        send_at(CH_ZERO + 8'd1, 11'd0, 11'd0);
        send_at(CH_J, 11'd7, 11'd5);
        send_at(CH_ESC, 11'd0, 11'd0);
        send_at(CH_LBRACKET, 11'd0, 11'd0);
        send_at(CH_ZERO + 8'd5, 11'd0, 11'd0);
        send_at(CH_SEMI, 11'd0, 11'd0);
        send_at(CH_ZERO + 8'd3, 11'd0, 11'd0);
        send_at(CH_H, 11'd0, 11'd0);

        random_phase(300);
        write_config(1023, 1023, 1, 1, 1'b0, 1'b0);
        random_phase(300);
        write_config(1, 1, 64, 64, 1'b1, 1'b0);
        random_phase(300);
        write_config($urandom_range(1, 1023), $urandom_range(1, 1023),
                     $urandom_range(1, 64), $urandom_range(1, 64),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        random_phase(300);
        steady = 1;
        write_config(640, 480, 64, 1, 1'b0, 1'b1);
        random_phase(300);
        steady = 0;
        write_config($urandom_range(1, 1023), $urandom_range(1, 1023),
                     $urandom_range(1, 64), $urandom_range(1, 64),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        random_phase(300);

        sb.report_leftovers();
        if (sb.errors == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/aecp_pkg.sv
rtl/aecp_front.sv
rtl/aecp_queue.sv
rtl/aecp_back.sv
rtl/ansi_escape_cursor_parser.sv
sim/aecp_check_pkg.sv
sim/tb.sv
